[hdl/ttw_pkg.sv]
`timescale 1ns / 1ps
// shared constants for the text terminal writer
package ttw_pkg;

  localparam int SCREEN_WIDTH_DEF  = 80;
  localparam int SCREEN_HEIGHT_DEF = 25;
  localparam int TAB_STOP_DEF      = 4;

  localparam int CODE_W      = 8;
  localparam int COLOR_W     = 8;
  localparam int CELL_W      = 16;
  localparam int ROW_FIELD_W = 5;
  localparam int COL_FIELD_W = 7;

  localparam logic [CODE_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CODE_W-1:0] CH_TAB       = 8'd9;
  localparam logic [CODE_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CODE_W-1:0] CH_SPACE     = 8'd32;

  localparam logic [CELL_W-1:0]  BLANK_RESET = 16'h0F20;
  localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h0F;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

endpackage

[hdl/ttw_cell_store.sv]
`timescale 1ns / 1ps
// screen cell memory addressed by logical row through a rotating top-row offset
module ttw_cell_store #(
  parameter int SCREEN_WIDTH  = ttw_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = ttw_pkg::SCREEN_HEIGHT_DEF,
  localparam int RW = $clog2(SCREEN_HEIGHT),
  localparam int CW = $clog2(SCREEN_WIDTH)
) (
  input  logic                        clk,
  input  logic [RW-1:0]               top,
  input  logic                        wr_en,
  input  logic [RW-1:0]               wr_row,
  input  logic [CW-1:0]               wr_col,
  input  logic [ttw_pkg::CELL_W-1:0]  wr_data,
  input  logic                        rd_en,
  input  logic [RW-1:0]               rd_row,
  input  logic [CW-1:0]               rd_col,
  output logic [ttw_pkg::CELL_W-1:0]  rd_data
);

  localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW = $clog2(DEPTH);
  localparam logic [RW:0]   HGT = SCREEN_HEIGHT[RW:0];
  localparam logic [AW-1:0] WID = SCREEN_WIDTH[AW-1:0];

  logic [ttw_pkg::CELL_W-1:0] mem [DEPTH];
  logic [ttw_pkg::CELL_W-1:0] rd_data_r;
  logic [AW-1:0]              wr_addr;
  logic [AW-1:0]              rd_addr;

  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] row,
                                             input logic [RW-1:0] base);
    logic [RW:0] sum;
    sum = {1'b0, row} + {1'b0, base};
    if (sum >= HGT) begin
      sum = sum - HGT;
    end
    return sum[RW-1:0];
  endfunction

  assign wr_addr = AW'(phys_row(wr_row, top)) * WID + AW'(wr_col);
  assign rd_addr = AW'(phys_row(rd_row, top)) * WID + AW'(rd_col);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/ttw_line_store.sv]
`timescale 1ns / 1ps
// per-row line end memory with the tab phase of each line end
module ttw_line_store #(
  parameter int SCREEN_WIDTH  = ttw_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = ttw_pkg::SCREEN_HEIGHT_DEF,
  parameter int TAB_STOP      = ttw_pkg::TAB_STOP_DEF,
  localparam int RW  = $clog2(SCREEN_HEIGHT),
  localparam int LW  = $clog2(SCREEN_WIDTH + 1),
  localparam int PHW = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1
) (
  input  logic           clk,
  input  logic [RW-1:0]  top,
  input  logic           wr_en,
  input  logic [RW-1:0]  wr_row,
  input  logic [LW-1:0]  wr_len,
  input  logic [PHW-1:0] wr_ph,
  input  logic           rd_en,
  input  logic [RW-1:0]  rd_row,
  output logic [LW-1:0]  rd_len,
  output logic [PHW-1:0] rd_ph
);

  localparam logic [RW:0] HGT = SCREEN_HEIGHT[RW:0];

  logic [LW+PHW-1:0] mem [SCREEN_HEIGHT];
  logic [LW+PHW-1:0] rd_word_r;

  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] row,
                                             input logic [RW-1:0] base);
    logic [RW:0] sum;
    sum = {1'b0, row} + {1'b0, base};
    if (sum >= HGT) begin
      sum = sum - HGT;
    end
    return sum[RW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[phys_row(wr_row, top)] <= {wr_len, wr_ph};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word_r <= mem[phys_row(rd_row, top)];
    end
  end

  assign rd_len = rd_word_r[LW+PHW-1:PHW];
  assign rd_ph  = rd_word_r[PHW-1:0];

endmodule

[hdl/text_terminal_writer.sv]
`timescale 1ns / 1ps
// text terminal writer top level: command sequencer, cursor state and result register
//
// After reset the block sweeps the whole screen to blanks, one cell per cycle, and
// stalls its input until the sweep ends. Each item then runs from acceptance to
// S_DONE: a printable character through S_WRITE, a newline through S_NEXT, a read
// of a cell on the screen through S_READ; a read off the screen or a backspace goes
// straight to S_DONE, but a backspace at column zero below the top row first passes
// S_BSLEN to read the previous line end from memory. A tab passes S_WRITE once per
// padding space. A wrap at the right edge adds S_NEXT, and a scroll adds S_BLANK,
// where the new bottom row is blanked through the single write port of the cell
// memory. Scrolling itself moves no data: a top-row offset rotates the rows.
// A finished result waits in the output register while the next item is taken.
module text_terminal_writer #(
  parameter int SCREEN_WIDTH  = ttw_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = ttw_pkg::SCREEN_HEIGHT_DEF,
  parameter int TAB_STOP      = ttw_pkg::TAB_STOP_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [ttw_pkg::COLOR_W-1:0]      cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_command,
  input  logic [ttw_pkg::CODE_W-1:0]       in_char_code,
  input  logic [ttw_pkg::ROW_FIELD_W-1:0]  in_read_row,
  input  logic [ttw_pkg::COL_FIELD_W-1:0]  in_read_col,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ttw_pkg::CELL_W-1:0]       out_cell_entry,
  output logic [ttw_pkg::ROW_FIELD_W-1:0]  out_cursor_row,
  output logic [ttw_pkg::COL_FIELD_W-1:0]  out_cursor_col,
  output logic                             out_scrolled
);

  localparam int RW   = $clog2(SCREEN_HEIGHT);
  localparam int CW   = $clog2(SCREEN_WIDTH);
  localparam int LW   = $clog2(SCREEN_WIDTH + 1);
  localparam int PHW  = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
  localparam int TCW  = $clog2(TAB_STOP + 1);
  localparam int OROW = ttw_pkg::ROW_FIELD_W;
  localparam int OCOL = ttw_pkg::COL_FIELD_W;

  localparam logic [RW-1:0]  LAST_ROW = RW'(SCREEN_HEIGHT - 1);
  localparam logic [CW-1:0]  LAST_COL = CW'(SCREEN_WIDTH - 1);
  localparam logic [LW-1:0]  WID_LEN  = LW'(SCREEN_WIDTH);
  localparam logic [PHW-1:0] TS_LAST  = PHW'(TAB_STOP - 1);
  localparam logic [PHW-1:0] WRAP_PH  = PHW'(SCREEN_WIDTH % TAB_STOP);
  localparam logic [TCW-1:0] TS_CNT   = TCW'(TAB_STOP);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WRITE = 3'd2;
  localparam logic [2:0] S_NEXT  = 3'd3;
  localparam logic [2:0] S_BLANK = 3'd4;
  localparam logic [2:0] S_BSLEN = 3'd5;
  localparam logic [2:0] S_READ  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]                    state_r, state_nxt;
  logic [RW-1:0]                 row_r, row_nxt;
  logic [CW-1:0]                 col_r, col_nxt;
  logic [PHW-1:0]                ph_r, ph_nxt;
  logic [RW-1:0]                 top_r, top_nxt;
  logic [TCW-1:0]                cnt_r, cnt_nxt;
  logic [RW-1:0]                 fill_row_r, fill_row_nxt;
  logic [CW-1:0]                 fill_col_r, fill_col_nxt;
  logic [ttw_pkg::CODE_W-1:0]    char_r, char_nxt;
  logic                          scr_r, scr_nxt;
  logic [ttw_pkg::CELL_W-1:0]    entry_r, entry_nxt;
  logic [ttw_pkg::COLOR_W-1:0]   color_r;

  logic                          out_valid_r;
  logic [ttw_pkg::CELL_W-1:0]    out_entry_r;
  logic [OROW-1:0]               out_row_r;
  logic [OCOL-1:0]               out_col_r;
  logic                          out_scr_r;

  logic                          accept;
  logic                          ld;
  logic                          rd_in_range;
  logic [PHW-1:0]                ph_inc, ph_dec, lr_ph_dec;
  logic [ttw_pkg::CELL_W-1:0]    blank_cell;

  logic                          cw_en;
  logic [RW-1:0]                 cw_row;
  logic [CW-1:0]                 cw_col;
  logic [ttw_pkg::CELL_W-1:0]    cw_data;
  logic                          cr_en;
  logic [RW-1:0]                 cr_row;
  logic [CW-1:0]                 cr_col;
  logic [ttw_pkg::CELL_W-1:0]    cr_data;

  logic                          lw_en;
  logic [RW-1:0]                 lw_row;
  logic [LW-1:0]                 lw_len;
  logic [PHW-1:0]                lw_ph;
  logic                          lr_en;
  logic [RW-1:0]                 lr_row;
  logic [LW-1:0]                 lr_len;
  logic [PHW-1:0]                lr_ph;

  ttw_cell_store #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_cell_store (
    .clk     (clk),
    .top     (top_r),
    .wr_en   (cw_en),
    .wr_row  (cw_row),
    .wr_col  (cw_col),
    .wr_data (cw_data),
    .rd_en   (cr_en),
    .rd_row  (cr_row),
    .rd_col  (cr_col),
    .rd_data (cr_data)
  );

  ttw_line_store #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .TAB_STOP      (TAB_STOP)
  ) u_line_store (
    .clk    (clk),
    .top    (top_r),
    .wr_en  (lw_en),
    .wr_row (lw_row),
    .wr_len (lw_len),
    .wr_ph  (lw_ph),
    .rd_en  (lr_en),
    .rd_row (lr_row),
    .rd_len (lr_len),
    .rd_ph  (lr_ph)
  );

  assign in_stall    = (state_r != S_IDLE);
  assign accept      = in_valid && !in_stall;
  assign ld          = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign rd_in_range = (int'(in_read_row) < SCREEN_HEIGHT) &&
                       (int'(in_read_col) < SCREEN_WIDTH);
  assign ph_inc      = (ph_r == TS_LAST) ? '0 : ph_r + 1'b1;
  assign ph_dec      = (ph_r == '0) ? TS_LAST : ph_r - 1'b1;
  assign lr_ph_dec   = (lr_ph == '0) ? TS_LAST : lr_ph - 1'b1;
  assign blank_cell  = {color_r, ttw_pkg::CH_SPACE};

  always_comb begin
    state_nxt    = state_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    ph_nxt       = ph_r;
    top_nxt      = top_r;
    cnt_nxt      = cnt_r;
    fill_row_nxt = fill_row_r;
    fill_col_nxt = fill_col_r;
    char_nxt     = char_r;
    scr_nxt      = scr_r;
    entry_nxt    = entry_r;
    cw_en        = 1'b0;
    cw_row       = row_r;
    cw_col       = col_r;
    cw_data      = blank_cell;
    cr_en        = 1'b0;
    cr_row       = RW'(in_read_row);
    cr_col       = CW'(in_read_col);
    lw_en        = 1'b0;
    lw_row       = row_r;
    lw_len       = '0;
    lw_ph        = '0;
    lr_en        = 1'b0;
    lr_row       = row_r - 1'b1;

    unique case (state_r)
      S_CLEAR: begin
        cw_en   = 1'b1;
        cw_row  = fill_row_r;
        cw_col  = fill_col_r;
        cw_data = ttw_pkg::BLANK_RESET;
        lw_en   = (fill_col_r == '0);
        lw_row  = fill_row_r;
        if (fill_col_r == LAST_COL) begin
          fill_col_nxt = '0;
          if (fill_row_r == LAST_ROW) begin
            fill_row_nxt = '0;
            state_nxt    = S_IDLE;
          end else begin
            fill_row_nxt = fill_row_r + 1'b1;
          end
        end else begin
          fill_col_nxt = fill_col_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          scr_nxt   = 1'b0;
          entry_nxt = '0;
          if (in_command == ttw_pkg::CMD_READ) begin
            if (rd_in_range) begin
              cr_en     = 1'b1;
              state_nxt = S_READ;
            end else begin
              state_nxt = S_DONE;
            end
          end else begin
            unique case (in_char_code)
              ttw_pkg::CH_TAB: begin
                cnt_nxt   = TS_CNT - TCW'(ph_r);
                char_nxt  = ttw_pkg::CH_SPACE;
                state_nxt = S_WRITE;
              end
              ttw_pkg::CH_NEWLINE: begin
                lw_en     = 1'b1;
                lw_len    = LW'(col_r);
                lw_ph     = ph_r;
                cnt_nxt   = '0;
                state_nxt = S_NEXT;
              end
              ttw_pkg::CH_BACKSPACE: begin
                if (col_r != '0) begin
                  col_nxt   = col_r - 1'b1;
                  ph_nxt    = ph_dec;
                  cw_en     = 1'b1;
                  cw_col    = col_r - 1'b1;
                  lw_en     = 1'b1;
                  lw_len    = LW'(col_r - 1'b1);
                  lw_ph     = ph_dec;
                  state_nxt = S_DONE;
                end else if (row_r == '0) begin
                  state_nxt = S_DONE;
                end else begin
                  row_nxt   = row_r - 1'b1;
                  lr_en     = 1'b1;
                  state_nxt = S_BSLEN;
                end
              end
              default: begin
                cnt_nxt   = TCW'(1);
                char_nxt  = in_char_code;
                state_nxt = S_WRITE;
              end
            endcase
          end
        end
      end
      S_WRITE: begin
        cw_en   = 1'b1;
        cw_data = {color_r, char_r};
        cnt_nxt = cnt_r - 1'b1;
        if (col_r == LAST_COL) begin
          lw_en     = 1'b1;
          lw_len    = WID_LEN;
          lw_ph     = WRAP_PH;
          state_nxt = S_NEXT;
        end else begin
          col_nxt = col_r + 1'b1;
          ph_nxt  = ph_inc;
          if (cnt_r == TCW'(1)) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_NEXT: begin
        col_nxt = '0;
        ph_nxt  = '0;
        if (row_r == LAST_ROW) begin
          top_nxt      = (top_r == LAST_ROW) ? '0 : top_r + 1'b1;
          scr_nxt      = 1'b1;
          fill_col_nxt = '0;
          state_nxt    = S_BLANK;
        end else begin
          row_nxt   = row_r + 1'b1;
          lw_en     = 1'b1;
          lw_row    = row_r + 1'b1;
          state_nxt = (cnt_r != '0) ? S_WRITE : S_DONE;
        end
      end
      S_BLANK: begin
        cw_en  = 1'b1;
        cw_row = LAST_ROW;
        cw_col = fill_col_r;
        lw_en  = (fill_col_r == '0);
        lw_row = LAST_ROW;
        if (fill_col_r == LAST_COL) begin
          fill_col_nxt = '0;
          state_nxt    = (cnt_r != '0) ? S_WRITE : S_DONE;
        end else begin
          fill_col_nxt = fill_col_r + 1'b1;
        end
      end
      S_BSLEN: begin
        if (lr_len == '0) begin
          col_nxt = '0;
          ph_nxt  = '0;
        end else begin
          col_nxt = CW'(lr_len - LW'(1));
          ph_nxt  = lr_ph_dec;
          cw_en   = 1'b1;
          cw_col  = CW'(lr_len - LW'(1));
          lw_en   = 1'b1;
          lw_len  = lr_len - LW'(1);
          lw_ph   = lr_ph_dec;
        end
        state_nxt = S_DONE;
      end
      S_READ: begin
        entry_nxt = cr_data;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (ld) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      row_r       <= '0;
      col_r       <= '0;
      ph_r        <= '0;
      top_r       <= '0;
      cnt_r       <= '0;
      fill_row_r  <= '0;
      fill_col_r  <= '0;
      color_r     <= ttw_pkg::COLOR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      row_r      <= row_nxt;
      col_r      <= col_nxt;
      ph_r       <= ph_nxt;
      top_r      <= top_nxt;
      cnt_r      <= cnt_nxt;
      fill_row_r <= fill_row_nxt;
      fill_col_r <= fill_col_nxt;
      if (cfg_wr_en) begin
        color_r <= cfg_wr_data;
      end
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    char_r  <= char_nxt;
    scr_r   <= scr_nxt;
    entry_r <= entry_nxt;
    if (ld) begin
      out_entry_r <= entry_r;
      out_row_r   <= OROW'(row_r);
      out_col_r   <= OCOL'(col_r);
      out_scr_r   <= scr_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_entry = out_entry_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;
  assign out_scrolled   = out_scr_r;

endmodule

[hdl/ttw_checker.sv]
`timescale 1ns / 1ps
// port-level checks for the text terminal writer and their binding
module ttw_checker #(
  parameter int SCREEN_WIDTH  = ttw_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = ttw_pkg::SCREEN_HEIGHT_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [ttw_pkg::CELL_W-1:0]       out_cell_entry,
  input logic [ttw_pkg::ROW_FIELD_W-1:0]  out_cursor_row,
  input logic [ttw_pkg::COL_FIELD_W-1:0]  out_cursor_col,
  input logic                             out_scrolled
);

  a_reset_empties_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending right after reset");

  a_stalled_item_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cell_entry) &&
      $stable(out_cursor_row) && $stable(out_cursor_col) && $stable(out_scrolled))
    else $error("stalled result item changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in work");

  a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_cursor_row) < SCREEN_HEIGHT) &&
      (int'(out_cursor_col) < SCREEN_WIDTH))
    else $error("cursor off screen");

  a_scroll_on_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_scrolled |->
      (SCREEN_HEIGHT > 32) || (int'(out_cursor_row) == SCREEN_HEIGHT - 1))
    else $error("scroll left cursor off the last row");

endmodule

bind text_terminal_writer ttw_checker #(
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_ttw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_cell_entry (out_cell_entry),
  .out_cursor_row (out_cursor_row),
  .out_cursor_col (out_cursor_col),
  .out_scrolled   (out_scrolled)
);
